// ===== rtl/btw_pkg.sv =====
package btw_pkg;

	localparam int DIGITS_DEF = 21;
	localparam int VALUE_W    = 31;
	localparam int WEIGHT_W   = 32;
	localparam int PROD_W     = 63;

	// floor(x / 3) == (x * RECIP3) >> 33 for any x below 2^32
	localparam logic [31:0] RECIP3     = 32'hAAAA_AAAB;
	localparam int          RECIP3_SHR = 33;

	typedef logic [1:0] digit_t;

	localparam digit_t DIG_ZERO = 2'd0;
	localparam digit_t DIG_POS  = 2'd1;
	localparam digit_t DIG_NEG  = 2'd2;

endpackage

// ===== rtl/balanced_ternary_weights.sv =====
// sequence: each accepted value runs through ST_MUL and ST_DIV once per digit on the
// shared reciprocal multiplier, then ST_CHK, then a scan of the digit positions for
// each pan that holds weights, one digit position per cycle unless the output stalls,
// ending at that pan's last weight; a new value is taken only back in ST_IDLE
// reset: arst_n clears the sequencer, counters and output register; the digit store and product register have none
module balanced_ternary_weights #(
	parameter int DIGITS = btw_pkg::DIGITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          value_valid,
	output logic                          value_stall,
	input  logic [btw_pkg::VALUE_W-1:0]   value,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic                          pan,
	output logic                          is_none,
	output logic [btw_pkg::WEIGHT_W-1:0]  weight,
	output logic                          last_of_pan,
	output logic                          last
);

	localparam int IDX_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;
	localparam int CNT_W = $clog2(DIGITS + 1);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DIGITS - 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_DIV  = 3'd2;
	localparam logic [2:0] ST_CHK  = 3'd3;
	localparam logic [2:0] ST_NEG  = 3'd4;
	localparam logic [2:0] ST_POS  = 3'd5;

	logic [2:0]                    state_q;
	logic [btw_pkg::VALUE_W-1:0]   rem_q;
	logic [btw_pkg::PROD_W-1:0]    prod_q;
	logic [IDX_W-1:0]              idx_q;
	logic [CNT_W-1:0]              neg_cnt_q;
	logic [CNT_W-1:0]              pos_cnt_q;
	logic [CNT_W-1:0]              seen_q;
	logic [btw_pkg::WEIGHT_W-1:0]  pow_q;
	btw_pkg::digit_t               digit_q [DIGITS];

	logic                          out_valid_q;
	logic                          pan_q;
	logic                          none_q;
	logic [btw_pkg::WEIGHT_W-1:0]  weight_q;
	logic                          lop_q;
	logic                          last_q;

	logic [29:0]                   quot;
	logic [btw_pkg::VALUE_W-1:0]   quot3;
	logic [1:0]                    rem3;
	logic                          emit_ok;
	btw_pkg::digit_t               cur_digit;
	logic [CNT_W-1:0]              seen_nx;
	logic [btw_pkg::WEIGHT_W-1:0]  pow_x3;

	assign quot      = prod_q[btw_pkg::PROD_W-1:btw_pkg::RECIP3_SHR];
	assign quot3     = {quot, 1'b0} + btw_pkg::VALUE_W'(quot);
	assign rem3      = 2'(rem_q - quot3);
	assign emit_ok   = !out_valid_q || !result_stall;
	assign cur_digit = digit_q[idx_q];
	assign seen_nx   = seen_q + CNT_W'(1);
	assign pow_x3    = {pow_q[btw_pkg::WEIGHT_W-2:0], 1'b0} + pow_q;

	assign value_stall  = (state_q != ST_IDLE);
	assign result_valid = out_valid_q;
	assign pan          = pan_q;
	assign is_none      = none_q;
	assign weight       = weight_q;
	assign last_of_pan  = lop_q;
	assign last         = last_q;

	// digit store, no reset
	always_ff @(posedge clk) begin
		if (state_q == ST_DIV) begin
			if (rem3 == 2'd2)
				digit_q[idx_q] <= btw_pkg::DIG_NEG;
			else if (rem3 == 2'd1)
				digit_q[idx_q] <= btw_pkg::DIG_POS;
			else
				digit_q[idx_q] <= btw_pkg::DIG_ZERO;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_MUL)
			prod_q <= btw_pkg::PROD_W'(rem_q) * btw_pkg::PROD_W'(btw_pkg::RECIP3);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rem_q       <= '0;
			idx_q       <= '0;
			neg_cnt_q   <= '0;
			pos_cnt_q   <= '0;
			seen_q      <= '0;
			pow_q       <= btw_pkg::WEIGHT_W'(1);
			out_valid_q <= 1'b0;
			pan_q       <= 1'b0;
			none_q      <= 1'b0;
			weight_q    <= '0;
			lop_q       <= 1'b0;
			last_q      <= 1'b0;
		end else begin
			if (out_valid_q && !result_stall)
				out_valid_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (value_valid) begin
						rem_q     <= value;
						idx_q     <= '0;
						neg_cnt_q <= '0;
						pos_cnt_q <= '0;
						state_q   <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					// a digit 2 becomes -1 and carries one upward
					rem_q <= btw_pkg::VALUE_W'(quot) + btw_pkg::VALUE_W'(rem3 == 2'd2);
					if (rem3 == 2'd2)
						neg_cnt_q <= neg_cnt_q + CNT_W'(1);
					else if (rem3 == 2'd1)
						pos_cnt_q <= pos_cnt_q + CNT_W'(1);
					if (idx_q == IDX_LAST) begin
						state_q <= ST_CHK;
					end else begin
						idx_q   <= idx_q + IDX_W'(1);
						state_q <= ST_MUL;
					end
				end
				ST_CHK: begin
					idx_q  <= '0;
					seen_q <= '0;
					pow_q  <= btw_pkg::WEIGHT_W'(1);
					if (neg_cnt_q != '0) begin
						state_q <= ST_NEG;
					end else if (emit_ok) begin
						// nothing on the object's pan: none marker
						out_valid_q <= 1'b1;
						pan_q       <= 1'b0;
						none_q      <= 1'b1;
						weight_q    <= '0;
						lop_q       <= 1'b1;
						last_q      <= (pos_cnt_q == '0);
						state_q     <= ST_POS;
					end
				end
				ST_NEG: begin
					if (cur_digit == btw_pkg::DIG_NEG) begin
						if (emit_ok) begin
							out_valid_q <= 1'b1;
							pan_q       <= 1'b0;
							none_q      <= 1'b0;
							weight_q    <= pow_q;
							lop_q       <= (seen_nx == neg_cnt_q);
							last_q      <= (seen_nx == neg_cnt_q) && (pos_cnt_q == '0);
							if (seen_nx == neg_cnt_q) begin
								idx_q   <= '0;
								seen_q  <= '0;
								pow_q   <= btw_pkg::WEIGHT_W'(1);
								state_q <= ST_POS;
							end else begin
								seen_q <= seen_nx;
								idx_q  <= idx_q + IDX_W'(1);
								pow_q  <= pow_x3;
							end
						end
					end else begin
						idx_q <= idx_q + IDX_W'(1);
						pow_q <= pow_x3;
					end
				end
				ST_POS: begin
					if (pos_cnt_q == '0) begin
						state_q <= ST_IDLE;
					end else if (cur_digit == btw_pkg::DIG_POS) begin
						if (emit_ok) begin
							out_valid_q <= 1'b1;
							pan_q       <= 1'b1;
							none_q      <= 1'b0;
							weight_q    <= pow_q;
							lop_q       <= (seen_nx == pos_cnt_q);
							last_q      <= (seen_nx == pos_cnt_q);
							if (seen_nx == pos_cnt_q) begin
								state_q <= ST_IDLE;
							end else begin
								seen_q <= seen_nx;
								idx_q  <= idx_q + IDX_W'(1);
								pow_q  <= pow_x3;
							end
						end
					end else begin
						idx_q <= idx_q + IDX_W'(1);
						pow_q <= pow_x3;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== rtl/btw_check.sv =====
module btw_check (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          value_valid,
	input  logic                          value_stall,
	input  logic [btw_pkg::VALUE_W-1:0]   value,
	input  logic                          result_valid,
	input  logic                          result_stall,
	input  logic                          pan,
	input  logic                          is_none,
	input  logic [btw_pkg::WEIGHT_W-1:0]  weight,
	input  logic                          last_of_pan,
	input  logic                          last
);

	// a stalled result beat stays offered
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result beat dropped while stalled");

	// the block reports busy in the cycle after it takes a value
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		value_valid && !value_stall |=> value_stall)
		else $error("new value taken straight after an accepted beat");

	a_none: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && is_none |-> !pan && (weight == '0) && last_of_pan)
		else $error("malformed none marker");

	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && last |-> last_of_pan)
		else $error("last beat not closing its pan");

	a_weight: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !is_none |-> (weight != '0))
		else $error("zero weight on a real beat");

endmodule

bind balanced_ternary_weights btw_check u_btw_check (.*);
